FILE: rtl/epa_pkg.sv
// Shared types and constants of the peak pressure alarm block.
package epa_pkg;

    localparam int ALPHA_BITS  = 9;
    localparam int WLEN_BITS   = 8;
    localparam int GAIN_BITS   = 16;
    localparam int THRESH_BITS = 18;
    localparam int PP_BITS     = 19;
    localparam int PADDR_BITS  = 4;
    localparam int PDATA_BITS  = 32;

    localparam int PP_MAX = 262143;
    localparam int PP_MIN = -262144;

    localparam logic [ALPHA_BITS-1:0] ALPHA_ONE = 9'd256;

    // Register indexes, taken from paddr[3:2]
    localparam logic [1:0] REG_ALPHA  = 2'd0;
    localparam logic [1:0] REG_WINDOW = 2'd1;
    localparam logic [1:0] REG_GAIN   = 2'd2;
    localparam logic [1:0] REG_THRESH = 2'd3;

    localparam logic [ALPHA_BITS-1:0]  ALPHA_RST  = 9'd179;
    localparam logic [WLEN_BITS-1:0]   WINDOW_RST = 8'd100;
    localparam logic [GAIN_BITS-1:0]   GAIN_RST   = 16'd6533;
    localparam logic [THRESH_BITS-1:0] THRESH_RST = 18'd8960;

    typedef struct packed {
        logic [ALPHA_BITS-1:0]  alpha;
        logic [WLEN_BITS-1:0]   wlen;
        logic [GAIN_BITS-1:0]   gain;
        logic [THRESH_BITS-1:0] thresh;
    } cfg_t;

    typedef struct packed {
        logic accept;
        logic mac;
        logic upd;
        logic scale;
        logic emit;
    } dp_cmd_t;

    typedef struct packed {
        logic baseline_valid;
        logic out_free;
    } dp_stat_t;

endpackage

FILE: rtl/epa_in_if.sv
// Sample request channel.
interface epa_in_if #(
    parameter int SAMPLE_BITS = 10
);
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink (input valid, input sample, output ready);
endinterface

FILE: rtl/epa_out_if.sv
// Result request channel.
interface epa_out_if #(
    parameter int SAMPLE_BITS = 10
);
    logic                     valid;
    logic                     ready;
    logic [SAMPLE_BITS-1:0]   filtered;
    logic                     baseline_captured;
    logic                     window_done;
    logic signed [SAMPLE_BITS:0] peak_excess;
    logic signed [18:0]       peak_pressure_q8;
    logic                     alarm;

    modport source (
        output valid, output filtered, output baseline_captured, output window_done,
        output peak_excess, output peak_pressure_q8, output alarm, input ready
    );
    modport sink (
        input valid, input filtered, input baseline_captured, input window_done,
        input peak_excess, input peak_pressure_q8, input alarm, output ready
    );
endinterface

FILE: rtl/ema_peak_pressure_alarm_top.sv
// Top level of the peak pressure alarm: sample channel, result channel, APB registers.
//
// Usage:
//   smp carries one raw converter sample per request; res returns exactly one
//   result per sample, in order. The first sample after reset is taken as the
//   baseline and seeds the moving average; later samples run the filter and the
//   peak window, and the sample that closes a window carries the peak excess,
//   the scaled peak pressure and the updated alarm.
//   The sequencer walks its steps in order: accept, filter products, average
//   update, gain product, saturate/emit; the baseline sample skips the filter
//   products and the average update. One sample is in work at a time, so a new
//   sample is taken only once the last result has gone into the result register.
//   The result register parts the two channels: while it waits to be taken the
//   next sample is accepted and worked on, and only the final step stalls until
//   the register is free.
//   Reset clears the baseline, the window count and the alarm, empties the result
//   register and loads defaults (alpha 179, window 100, gain 6533, threshold 8960).
//   The user writes registers through APB only while idle; the block does not enforce it.
module ema_peak_pressure_alarm_top #(
    parameter int SAMPLE_BITS = 10
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [epa_pkg::PADDR_BITS-1:0]       paddr,
    input  logic [epa_pkg::PDATA_BITS-1:0]       pwdata,
    output logic [epa_pkg::PDATA_BITS-1:0]       prdata,
    output logic                                 pready,
    epa_in_if.sink                               smp,
    epa_out_if.source                            res
);
    import epa_pkg::*;

    cfg_t     cfg;
    dp_cmd_t  cmd;
    dp_stat_t stat;
    logic     smp_ready;

    logic [SAMPLE_BITS-1:0]      dp_filtered;
    logic                        dp_captured;
    logic                        dp_done;
    logic signed [SAMPLE_BITS:0] dp_excess;
    logic signed [PP_BITS-1:0]   dp_pressure;
    logic                        dp_alarm;
    logic                        dp_valid;

    epa_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    epa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .smp_valid (smp.valid),
        .smp_ready (smp_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    epa_dp #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .cmd          (cmd),
        .stat         (stat),
        .sample       (smp.sample),
        .res_ready    (res.ready),
        .res_valid    (dp_valid),
        .res_filtered (dp_filtered),
        .res_captured (dp_captured),
        .res_done     (dp_done),
        .res_excess   (dp_excess),
        .res_pressure (dp_pressure),
        .res_alarm    (dp_alarm)
    );

    assign smp.ready             = smp_ready;
    assign res.valid             = dp_valid;
    assign res.filtered          = dp_filtered;
    assign res.baseline_captured = dp_captured;
    assign res.window_done       = dp_done;
    assign res.peak_excess       = dp_excess;
    assign res.peak_pressure_q8  = dp_pressure;
    assign res.alarm             = dp_alarm;
endmodule

FILE: rtl/epa_regs.sv
// APB configuration registers of the peak pressure alarm.
module epa_regs (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [epa_pkg::PADDR_BITS-1:0]       paddr,
    input  logic [epa_pkg::PDATA_BITS-1:0]       pwdata,
    output logic [epa_pkg::PDATA_BITS-1:0]       prdata,
    output logic                                 pready,
    output epa_pkg::cfg_t                        cfg
);
    import epa_pkg::*;

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[3:2];
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.alpha  <= ALPHA_RST;
            cfg_reg.wlen   <= WINDOW_RST;
            cfg_reg.gain   <= GAIN_RST;
            cfg_reg.thresh <= THRESH_RST;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_ALPHA:  cfg_reg.alpha  <= pwdata[ALPHA_BITS-1:0];
                REG_WINDOW: cfg_reg.wlen   <= pwdata[WLEN_BITS-1:0];
                REG_GAIN:   cfg_reg.gain   <= pwdata[GAIN_BITS-1:0];
                REG_THRESH: cfg_reg.thresh <= pwdata[THRESH_BITS-1:0];
                default:    cfg_reg        <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_ALPHA:  prdata = PDATA_BITS'(cfg_reg.alpha);
            REG_WINDOW: prdata = PDATA_BITS'(cfg_reg.wlen);
            REG_GAIN:   prdata = PDATA_BITS'(cfg_reg.gain);
            REG_THRESH: prdata = PDATA_BITS'(cfg_reg.thresh);
            default:    prdata = '0;
        endcase
    end
endmodule

FILE: rtl/epa_ctrl.sv
// Sequencing state machine of the peak pressure alarm.
module epa_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               smp_valid,
    output logic               smp_ready,
    input  epa_pkg::dp_stat_t  stat,
    output epa_pkg::dp_cmd_t   cmd
);
    import epa_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MAC   = 3'd1;
    localparam logic [2:0] S_UPD   = 3'd2;
    localparam logic [2:0] S_SCALE = 3'd3;
    localparam logic [2:0] S_EMIT  = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign smp_ready = (state_reg == S_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (smp_valid)
                begin
                    cmd.accept = 1'b1;
                    // a capture skips the filter and the window
                    state_next = stat.baseline_valid ? S_MAC : S_SCALE;
                end
            end
            S_MAC:
            begin
                cmd.mac    = 1'b1;
                state_next = S_UPD;
            end
            S_UPD:
            begin
                cmd.upd    = 1'b1;
                state_next = S_SCALE;
            end
            S_SCALE:
            begin
                cmd.scale  = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                // hold until the result register is free
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end
endmodule

FILE: rtl/epa_dp.sv
// Filter, window and scaling datapath of the peak pressure alarm.
module epa_dp #(
    parameter int SAMPLE_BITS = 10
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  epa_pkg::cfg_t                         cfg,
    input  epa_pkg::dp_cmd_t                      cmd,
    output epa_pkg::dp_stat_t                     stat,
    input  logic [SAMPLE_BITS-1:0]                sample,
    input  logic                                  res_ready,
    output logic                                  res_valid,
    output logic [SAMPLE_BITS-1:0]                res_filtered,
    output logic                                  res_captured,
    output logic                                  res_done,
    output logic signed [SAMPLE_BITS:0]           res_excess,
    output logic signed [epa_pkg::PP_BITS-1:0]    res_pressure,
    output logic                                  res_alarm
);
    import epa_pkg::*;

    localparam int W  = SAMPLE_BITS;
    localparam int MW = W + ALPHA_BITS;
    localparam int SW = MW + 1;
    localparam int PW = W + 1 + GAIN_BITS + 1;
    localparam int QW = PW - 8;
    localparam int EW = (QW > PP_BITS + 1) ? QW : PP_BITS + 1;

    localparam logic signed [EW-1:0] Q_MAX = EW'(PP_MAX);
    localparam logic signed [EW-1:0] Q_MIN = EW'(PP_MIN);

    logic [W-1:0]          sample_reg;
    logic [W-1:0]          baseline_reg;
    logic                  baseline_valid_reg;
    logic [W-1:0]          average_reg;
    logic [WLEN_BITS-1:0]  count_reg;
    logic [W-1:0]          max_reg;
    logic [MW-1:0]         prod_new_reg;
    logic [MW-1:0]         prod_old_reg;
    logic signed [W:0]     excess_reg;
    logic                  done_reg;
    logic                  captured_reg;
    logic signed [PW-1:0]  scaled_reg;
    logic                  alarm_reg;
    logic                  res_valid_reg;
    logic [W-1:0]          res_filtered_reg;
    logic                  res_captured_reg;
    logic                  res_done_reg;
    logic signed [W:0]     res_excess_reg;
    logic signed [PP_BITS-1:0] res_pressure_reg;
    logic                  res_alarm_reg;

    logic [ALPHA_BITS-1:0] a_sat;
    logic [ALPHA_BITS-1:0] a_rest;
    logic [SW-1:0]         mac_sum;
    logic [W-1:0]          avg_new;
    logic [W-1:0]          max_new;
    logic [WLEN_BITS-1:0]  cnt_inc;
    logic [WLEN_BITS-1:0]  len_eff;
    logic                  win_close;
    logic signed [W:0]     excess_new;
    logic signed [PW-1:0]  scaled_shr;
    logic signed [EW-1:0]  q_wide;
    logic signed [EW-1:0]  q_sat;
    logic signed [PP_BITS-1:0] pressure;
    logic                  over_limit;

    assign a_sat  = (cfg.alpha > ALPHA_ONE) ? ALPHA_ONE : cfg.alpha;
    assign a_rest = ALPHA_ONE - a_sat;

    assign mac_sum    = SW'(prod_new_reg) + SW'(prod_old_reg);
    assign avg_new    = mac_sum[W+7:8];
    assign max_new    = ((count_reg == '0) || (avg_new > max_reg)) ? avg_new : max_reg;
    assign cnt_inc    = count_reg + WLEN_BITS'(1);
    assign len_eff    = (cfg.wlen == '0) ? WLEN_BITS'(1) : cfg.wlen;
    assign win_close  = (cnt_inc >= len_eff);
    assign excess_new = $signed({1'b0, max_new}) - $signed({1'b0, baseline_reg});

    // arithmetic shift floors toward minus infinity
    assign scaled_shr = scaled_reg >>> 8;
    assign q_wide     = EW'(scaled_shr);
    assign q_sat      = (q_wide > Q_MAX) ? Q_MAX : ((q_wide < Q_MIN) ? Q_MIN : q_wide);
    assign pressure   = q_sat[PP_BITS-1:0];
    assign over_limit = $signed({pressure[PP_BITS-1], pressure})
                        > $signed({2'b00, cfg.thresh});

    assign stat.baseline_valid = baseline_valid_reg;
    assign stat.out_free       = !res_valid_reg || res_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            baseline_valid_reg <= 1'b0;
            count_reg          <= '0;
            alarm_reg          <= 1'b0;
            res_valid_reg      <= 1'b0;
        end
        else
        begin
            if (cmd.accept && !baseline_valid_reg)
            begin
                baseline_valid_reg <= 1'b1;
            end
            if (cmd.upd)
            begin
                count_reg <= win_close ? '0 : cnt_inc;
            end
            if (cmd.emit && done_reg)
            begin
                alarm_reg <= over_limit;
            end
            if (cmd.emit)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            sample_reg <= sample;
            if (!baseline_valid_reg)
            begin
                baseline_reg <= sample;
                average_reg  <= sample;
                captured_reg <= 1'b1;
                done_reg     <= 1'b0;
                excess_reg   <= '0;
            end
            else
            begin
                captured_reg <= 1'b0;
            end
        end
        if (cmd.mac)
        begin
            prod_new_reg <= MW'(a_sat) * MW'(sample_reg);
            prod_old_reg <= MW'(a_rest) * MW'(average_reg);
        end
        if (cmd.upd)
        begin
            average_reg <= avg_new;
            max_reg     <= max_new;
            done_reg    <= win_close;
            excess_reg  <= win_close ? excess_new : '0;
        end
        if (cmd.scale)
        begin
            scaled_reg <= PW'(excess_reg) * PW'($signed({1'b0, cfg.gain}));
        end
        if (cmd.emit)
        begin
            res_filtered_reg <= average_reg;
            res_captured_reg <= captured_reg;
            res_done_reg     <= done_reg;
            res_excess_reg   <= excess_reg;
            res_pressure_reg <= pressure;
            res_alarm_reg    <= done_reg ? over_limit : alarm_reg;
        end
    end

    assign res_valid    = res_valid_reg;
    assign res_filtered = res_filtered_reg;
    assign res_captured = res_captured_reg;
    assign res_done     = res_done_reg;
    assign res_excess   = res_excess_reg;
    assign res_pressure = res_pressure_reg;
    assign res_alarm    = res_alarm_reg;

`ifndef SYNTHESIS
    a_cap_not_done: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> !(res_captured_reg && res_done_reg))
        else $error("capture result also closed a window");

    a_baseline_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        baseline_valid_reg |=> baseline_valid_reg)
        else $error("baseline lost without reset");

    a_alarm_update: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && done_reg) |=> (alarm_reg == $past(over_limit)
                                    && res_alarm_reg == alarm_reg))
        else $error("alarm not updated on window close");
`endif
endmodule
